[hdl/wscs_pkg.sv]
// Shared types, codes and the microcode store of the watchdog SPI command sequencer.
// Used by wscs_useq and watchdog_spi_command_sequencer; depends on nothing else.
`timescale 1ns / 1ps

package wscs_pkg;

    localparam int UPC_W = 5;

    typedef logic [UPC_W-1:0] upc_addr_t;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_REPLY = 1'b1;

    localparam logic [1:0] STG_SETUP   = 2'd0;
    localparam logic [1:0] STG_CHANNEL = 2'd1;
    localparam logic [1:0] STG_RUN     = 2'd2;

    localparam upc_addr_t ADDR_SETUP   = 5'd0;
    localparam upc_addr_t ADDR_DIAG    = 5'd10;
    localparam upc_addr_t ADDR_HB_A    = 5'd25;
    localparam upc_addr_t ADDR_HB_B    = 5'd27;
    localparam upc_addr_t ADDR_CHANNEL = 5'd29;

    localparam logic [15:0] ROT_CMD_RESET = 16'h011F;
    localparam logic [15:0] ROT_CMD_READ  = 16'h0F00;

    typedef enum logic [1:0] {
        SRC_CONST,
        SRC_ROT_CMD,
        SRC_ROT_VAL
    } word_src_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_END,
        SEQ_ROT,
        SEQ_HB
    } seq_op_t;

    typedef struct packed {
        word_src_t   src;
        logic [15:0] data;
        logic        frame_start;
        logic        frame_end;
        seq_op_t     seq;
    } ctrl_word_t;

    typedef struct packed {
        logic      valid;
        upc_addr_t entry;
        logic      do_rot;
        logic      hb_a;
        logic      hb_b;
    } wscs_start_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } useq_state_t;

    function automatic ctrl_word_t cw(input word_src_t src, input logic [15:0] data,
                                      input logic fs, input logic fe, input seq_op_t seq);
        ctrl_word_t w;
        w.src         = src;
        w.data        = data;
        w.frame_start = fs;
        w.frame_end   = fe;
        w.seq         = seq;
        return w;
    endfunction

    // Setup, diagnostic, rotating/status, heartbeat and channel-group programs.
    function automatic ctrl_word_t wscs_ucode(input upc_addr_t addr);
        ctrl_word_t w;
        w = cw(SRC_CONST, 16'h0000, 1'b0, 1'b0, SEQ_NEXT);
        case (addr)
            5'd0:  w = cw(SRC_CONST, 16'h0F1A, 1'b1, 1'b0, SEQ_NEXT);
            5'd1:  w = cw(SRC_CONST, 16'h0082, 1'b0, 1'b1, SEQ_NEXT);
            5'd2, 5'd4, 5'd6, 5'd8:
                   w = cw(SRC_CONST, 16'h0F1D, 1'b1, 1'b0, SEQ_NEXT);
            5'd3, 5'd5, 5'd7, 5'd9:
                   w = cw(SRC_CONST, 16'h04F0, 1'b0, 1'b1, SEQ_NEXT);
            5'd10: w = cw(SRC_CONST, 16'h835F, 1'b1, 1'b0, SEQ_NEXT);
            5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17:
                   w = cw(SRC_CONST, 16'h0000, 1'b0, 1'b0, SEQ_NEXT);
            5'd18: w = cw(SRC_CONST, 16'h0000, 1'b0, 1'b1, SEQ_ROT);
            5'd19: w = cw(SRC_ROT_CMD, 16'h0000, 1'b1, 1'b0, SEQ_NEXT);
            5'd20: w = cw(SRC_ROT_VAL, 16'h0000, 1'b0, 1'b1, SEQ_NEXT);
            5'd21: w = cw(SRC_CONST, 16'h0B01, 1'b1, 1'b0, SEQ_NEXT);
            5'd22, 5'd23:
                   w = cw(SRC_CONST, 16'h0000, 1'b0, 1'b0, SEQ_NEXT);
            5'd24: w = cw(SRC_CONST, 16'h1FC0, 1'b0, 1'b1, SEQ_HB);
            5'd25: w = cw(SRC_CONST, 16'h0F14, 1'b1, 1'b0, SEQ_NEXT);
            5'd26: w = cw(SRC_CONST, 16'h3A20, 1'b0, 1'b1, SEQ_END);
            5'd27: w = cw(SRC_CONST, 16'h0F14, 1'b1, 1'b0, SEQ_NEXT);
            5'd28: w = cw(SRC_CONST, 16'h3E20, 1'b0, 1'b1, SEQ_END);
            5'd29: w = cw(SRC_CONST, 16'h0F52, 1'b1, 1'b0, SEQ_NEXT);
            5'd30: w = cw(SRC_CONST, 16'h7575, 1'b0, 1'b0, SEQ_NEXT);
            5'd31: w = cw(SRC_CONST, 16'h0055, 1'b0, 1'b1, SEQ_END);
            default: w = cw(SRC_CONST, 16'h0000, 1'b0, 1'b0, SEQ_END);
        endcase
        return w;
    endfunction

endpackage

[hdl/wscs_useq.sv]
// Microcoded word sequencer: step counter, control-word decode and output register.
// Depends on wscs_pkg for the control word format and the microcode store.
`timescale 1ns / 1ps

module wscs_useq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wscs_pkg::wscs_start_t start,
    input  logic [15:0]          rot_command,
    input  logic [15:0]          rot_value,
    output logic                 busy,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [15:0]          m_tx_word,
    output logic                 m_frame_start,
    output logic                 m_frame_end,
    output logic                 m_run_last
);
    import wscs_pkg::*;

    useq_state_t state_reg, state_next;
    upc_addr_t   pc_reg, pc_next;
    logic        do_rot_reg, hb_a_reg, hb_b_reg;
    logic        m_valid_reg, m_valid_next;
    logic [15:0] word_reg;
    logic        fs_reg, fe_reg, last_reg;

    ctrl_word_t  cw_cur;
    logic [15:0] word_sel;
    logic        is_last;
    upc_addr_t   hb_target;
    logic        load;

    assign cw_cur    = wscs_ucode(pc_reg);
    assign load      = (state_reg == ST_RUN) && (!m_valid_reg || m_ready);
    assign hb_target = hb_a_reg ? ADDR_HB_A : ADDR_HB_B;

    always_comb begin
        case (cw_cur.src)
            SRC_ROT_CMD: word_sel = rot_command;
            SRC_ROT_VAL: word_sel = rot_value;
            default:     word_sel = cw_cur.data;
        endcase
    end

    always_comb begin
        is_last = 1'b0;
        pc_next = pc_reg + 5'd1;
        case (cw_cur.seq)
            SEQ_NEXT: begin
                is_last = 1'b0;
            end
            SEQ_END: begin
                is_last = 1'b1;
            end
            SEQ_ROT: begin
                if (!do_rot_reg) begin
                    pc_next = hb_target;
                    is_last = !hb_a_reg && !hb_b_reg;
                end
            end
            SEQ_HB: begin
                pc_next = hb_target;
                is_last = !hb_a_reg && !hb_b_reg;
            end
            default: begin
                is_last = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start.valid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (load && is_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            pc_reg      <= ADDR_SETUP;
            do_rot_reg  <= 1'b0;
            hb_a_reg    <= 1'b0;
            hb_b_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if ((state_reg == ST_IDLE) && start.valid) begin
                pc_reg     <= start.entry;
                do_rot_reg <= start.do_rot;
                hb_a_reg   <= start.hb_a;
                hb_b_reg   <= start.hb_b;
            end else if (load) begin
                pc_reg <= pc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= word_sel;
            fs_reg   <= cw_cur.frame_start;
            fe_reg   <= cw_cur.frame_end;
            last_reg <= is_last;
        end
    end

    assign busy          = (state_reg == ST_RUN);
    assign m_valid       = m_valid_reg;
    assign m_tx_word     = word_reg;
    assign m_frame_start = fs_reg;
    assign m_frame_end   = fe_reg;
    assign m_run_last    = last_reg;

endmodule

[hdl/watchdog_spi_command_sequencer.sv]
// Top level of the watchdog SPI command sequencer: service state and reply handling.
// Depends on wscs_pkg and instantiates wscs_useq, which emits the frame words.
// The input channel (s_valid/s_ready) carries either a service tick (s_cmd low) or a
// rotating diagnostic reply (s_cmd high, with s_reply_word and s_reply_count).
// A reply transaction updates the rotating command state and produces no words.
// A tick transaction produces a run of 16-bit words on the result channel
// (m_valid/m_ready), each tagged with frame start, frame end and a run-last flag.
// The first tick produces 25 words, the second 3, and later ticks 9 to 17.
// Accepting a tick loads the microcode step counter, and the first word is then registered
// in the output register; one word follows per cycle while m_ready stays high, as the
// microcode step counter advances one step per word loaded into the output register.
// s_ready is low while a run is in progress and rises once the last word sits in
// the output register, so the next transaction can be taken while it waits.
// A stall on m_ready holds the current word and the step counter in place.
// Synchronous reset returns the block to its first startup stage with the
// rotating command at its default, no diagnostic pending and no word presented.
`timescale 1ns / 1ps

module watchdog_spi_command_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [15:0] s_reply_word,
    input  logic [4:0]  s_reply_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_tx_word,
    output logic        m_frame_start,
    output logic        m_frame_end,
    output logic        m_run_last
);
    import wscs_pkg::*;

    logic [1:0]  stage_reg, stage_next;
    logic [1:0]  diag_cnt_reg, diag_cnt_next;
    logic [4:0]  hb_cnt_reg, hb_cnt_next;
    logic        pending_reg, pending_next;
    logic [15:0] rot_cmd_reg, rot_cmd_next;
    logic [15:0] rot_val_reg, rot_val_next;

    logic        busy;
    logic        accept;
    logic [1:0]  diag_inc;
    logic [4:0]  hb_inc;
    logic        rot_due;
    wscs_start_t start;

    function automatic logic [15:0] protect_bits(input logic [15:0] r);
        logic [5:0] w;
        logic       all5;
        logic       eq45;
        w    = r[5:0];
        all5 = &w[4:0];
        eq45 = ~(w[4] ^ w[5]);
        return {10'b0, w[4:0], all5 ^ eq45};
    endfunction

    assign s_ready  = !busy;
    assign accept   = s_valid && s_ready;
    assign diag_inc = diag_cnt_reg + 2'd1;
    assign hb_inc   = hb_cnt_reg + 5'd1;
    assign rot_due  = (diag_inc == 2'd0) && !pending_reg;

    always_comb begin
        stage_next    = stage_reg;
        diag_cnt_next = diag_cnt_reg;
        hb_cnt_next   = hb_cnt_reg;
        pending_next  = pending_reg;
        rot_cmd_next  = rot_cmd_reg;
        rot_val_next  = rot_val_reg;
        start         = '0;
        if (accept) begin
            if (s_cmd == CMD_REPLY) begin
                pending_next = 1'b0;
                if (s_reply_count >= 5'd2) begin
                    if (rot_cmd_reg[11:8] == 4'h1) begin
                        rot_val_next = protect_bits(s_reply_word);
                        rot_cmd_next = ROT_CMD_READ;
                    end else begin
                        rot_cmd_next = ROT_CMD_RESET;
                    end
                end
            end else begin
                start.valid = 1'b1;
                case (stage_reg)
                    STG_SETUP: begin
                        start.entry  = ADDR_SETUP;
                        start.do_rot = !pending_reg;
                        pending_next = 1'b1;
                        stage_next   = STG_CHANNEL;
                    end
                    STG_CHANNEL: begin
                        start.entry = ADDR_CHANNEL;
                        stage_next  = STG_RUN;
                    end
                    default: begin
                        start.entry   = ADDR_DIAG;
                        start.do_rot  = rot_due;
                        start.hb_a    = (hb_inc == 5'd30);
                        start.hb_b    = (hb_inc == 5'd31);
                        diag_cnt_next = diag_inc;
                        if (rot_due) begin
                            pending_next = 1'b1;
                        end
                        hb_cnt_next = (hb_inc == 5'd31) ? 5'd0 : hb_inc;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg    <= STG_SETUP;
            diag_cnt_reg <= 2'd0;
            hb_cnt_reg   <= 5'd0;
            pending_reg  <= 1'b0;
            rot_cmd_reg  <= ROT_CMD_RESET;
            rot_val_reg  <= 16'h0000;
        end else begin
            stage_reg    <= stage_next;
            diag_cnt_reg <= diag_cnt_next;
            hb_cnt_reg   <= hb_cnt_next;
            pending_reg  <= pending_next;
            rot_cmd_reg  <= rot_cmd_next;
            rot_val_reg  <= rot_val_next;
        end
    end

    wscs_useq u_useq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (start),
        .rot_command   (rot_cmd_reg),
        .rot_value     (rot_val_reg),
        .busy          (busy),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tx_word     (m_tx_word),
        .m_frame_start (m_frame_start),
        .m_frame_end   (m_frame_end),
        .m_run_last    (m_run_last)
    );

endmodule
